// File: sv/idaz_pkg.sv
package idaz_pkg;

    localparam int DIST_W      = 15;
    localparam int LIMIT_W     = 7;
    localparam int INTERVAL_W  = 16;
    localparam int TIME_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int FRAC_W      = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_NEAR_LIMIT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIDDLE_LIMIT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FAR_LIMIT      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_INTERVAL = 3'd4;

    localparam logic [LIMIT_W-1:0]    NEAR_LIMIT_RST     = 7'd10;
    localparam logic [LIMIT_W-1:0]    MIDDLE_LIMIT_RST   = 7'd30;
    localparam logic [LIMIT_W-1:0]    FAR_LIMIT_RST      = 7'd50;
    localparam logic [LIMIT_W-1:0]    RANGE_LIMIT_RST    = 7'd80;
    localparam logic [INTERVAL_W-1:0] BLINK_INTERVAL_RST = 16'd500;

    localparam logic [DIST_W-1:0] DIST_MAX = 15'h7fff;

    typedef struct packed {
        logic [LIMIT_W-1:0]    near_limit_cm;
        logic [LIMIT_W-1:0]    middle_limit_cm;
        logic [LIMIT_W-1:0]    far_limit_cm;
        logic [LIMIT_W-1:0]    range_limit_cm;
        logic [INTERVAL_W-1:0] blink_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] distance_q8;
        logic              far_on;
        logic              middle_on;
        logic              near_on;
        logic              alarm_active;
        logic              alarm_red;
    } t_result;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int i = 0; i < 32; i++) begin
            if (b != 64'd0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
        end
        return res;
    endfunction

    // floor(log2(x) * 2^16) by repeated squaring in q30
    function automatic longint log2_q16(input logic [63:0] x);
        int          n;
        logic [63:0] y;
        longint      r;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) begin
                n = i;
            end
        end
        y = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
        r = longint'(n) * 65536;
        for (int i = 15; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                r = r + (longint'(1) << i);
            end
        end
        return r;
    endfunction

    // 2^(f / 2^16) in q30
    function automatic logic [63:0] pow2_frac_q30(input logic [15:0] f);
        logic [63:0] acc;
        logic [63:0] root;
        acc  = 64'd1 << 30;
        root = 64'd2 << 30;
        for (int i = 15; i >= 0; i--) begin
            root = isqrt64(root << 30);
            if (f[i]) begin
                acc = (acc * root) >> 30;
            end
        end
        return acc;
    endfunction

    // curve breakpoint for a nonzero mean held as q16
    function automatic logic [DIST_W-1:0] curve_entry(input logic [63:0] mq);
        longint      lead;
        longint      t;
        longint      e;
        int          n;
        logic [63:0] v;
        lead = log2_q16(64'd40797) + (longint'(8) <<< 16);
        t    = log2_q16(mq) - (longint'(16) <<< 16);
        e    = lead - (t * 1284) / 1000;
        if (e < 0) begin
            v = '0;
        end else if (e >= (longint'(15) <<< 16)) begin
            v = 64'(DIST_MAX);
        end else begin
            n = int'(e >>> 16);
            v = (pow2_frac_q30(e[15:0]) << n) >> 30;
            if (v > 64'(DIST_MAX)) begin
                v = 64'(DIST_MAX);
            end
        end
        return v[DIST_W-1:0];
    endfunction

endpackage

// File: sv/idaz_ram.sv
module idaz_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: sv/idaz_queue.sv
module idaz_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_wr_ok;
    logic             w_rd_ok;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign w_wr_ok   = i_wr && !o_full;
    assign w_rd_ok   = i_rd && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr_ok) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_rd_ok) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({w_wr_ok, w_rd_ok})
            2'b10: begin
                n_count = r_count + CNT_W'(1);
            end
            2'b01: begin
                n_count = r_count - CNT_W'(1);
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// File: sv/idaz_front.sv
module idaz_front #(
    parameter int WINDOW      = 10,
    parameter int SAMPLE_BITS = 10,
    parameter int SUM_W       = 14
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  logic                   i_full,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_wr,
    output logic [SUM_W-1:0]       o_sum
);

    localparam int SLOT_W = $clog2(WINDOW);

    logic [SLOT_W-1:0]      r_slot;
    logic [SLOT_W-1:0]      n_slot;
    logic                   r_wrapped;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       n_sum;
    logic [SAMPLE_BITS-1:0] w_ram_rd;
    logic [SAMPLE_BITS-1:0] w_old;
    logic                   w_accept;
    logic                   w_last_slot;

    assign w_accept    = i_push && !i_full;
    assign w_last_slot = (r_slot == SLOT_W'(WINDOW - 1));
    // slots not yet written since reset count as zero
    assign w_old       = r_wrapped ? w_ram_rd : '0;
    assign n_sum       = r_sum - SUM_W'(w_old) + SUM_W'(i_sample);

    always_comb begin
        n_slot = r_slot;
        if (w_accept) begin
            n_slot = w_last_slot ? '0 : r_slot + SLOT_W'(1);
        end
    end

    idaz_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_accept),
        .i_wr_addr (r_slot),
        .i_wr_data (i_sample),
        .i_rd_addr (n_slot),
        .o_rd_data (w_ram_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot    <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
        end else begin
            r_slot <= n_slot;
            if (w_accept) begin
                r_sum <= n_sum;
                if (w_last_slot) begin
                    r_wrapped <= 1'b1;
                end
            end
        end
    end

    assign o_wr  = w_accept;
    assign o_sum = n_sum;

endmodule

// File: sv/idaz_back.sv
module idaz_back #(
    parameter int WINDOW         = 10,
    parameter int SAMPLE_BITS    = 10,
    parameter int CURVE_SEGMENTS = 64,
    parameter int SUM_W          = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  idaz_pkg::t_cfg               i_cfg,
    input  logic                         i_item_avail,
    input  logic [SUM_W-1:0]             i_sum,
    input  logic [idaz_pkg::TIME_W-1:0]  i_time_ms,
    output logic                         o_pop,
    input  logic                         i_res_full,
    output logic                         o_res_wr,
    output idaz_pkg::t_result            o_result
);

    localparam int DIST_W = idaz_pkg::DIST_W;
    localparam int TIME_W = idaz_pkg::TIME_W;
    localparam int SEG_W  = $clog2(CURVE_SEGMENTS + 1);
    localparam int NUM_W  = SUM_W + SEG_W;
    localparam int A_W    = NUM_W - SAMPLE_BITS;
    localparam int K_W    = $clog2(CURVE_SEGMENTS);
    localparam int RW_W   = $clog2(WINDOW);
    localparam int REM_W  = RW_W + SAMPLE_BITS;
    localparam int P2_W   = DIST_W + REM_W;
    localparam int B_W    = DIST_W + RW_W;
    localparam logic [A_W-1:0] M1 = A_W'((64'd1 << A_W) / WINDOW);
    localparam logic [B_W-1:0] M2 = B_W'((64'd1 << B_W) / WINDOW);

    logic [DIST_W-1:0] w_curve [CURVE_SEGMENTS + 1];

    for (genvar kk = 0; kk <= CURVE_SEGMENTS; kk++) begin : g_curve
        if (kk == 0) begin : g_first
            assign w_curve[kk] = idaz_pkg::DIST_MAX;
        end else begin : g_point
            localparam logic [63:0] MQ =
                (64'(kk) << (SAMPLE_BITS + 16)) / CURVE_SEGMENTS;
            localparam logic [DIST_W-1:0] ENTRY = idaz_pkg::curve_entry(MQ);
            assign w_curve[kk] = ENTRY;
        end
    end

    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;

    logic [A_W-1:0]         r1_a;
    logic [SAMPLE_BITS-1:0] r1_lo;
    logic [TIME_W-1:0]      r1_time;
    logic [A_W-1:0]         r2_q0;
    logic [A_W-1:0]         r2_a;
    logic [SAMPLE_BITS-1:0] r2_lo;
    logic [TIME_W-1:0]      r2_time;
    logic [K_W-1:0]         r3_k;
    logic [REM_W-1:0]       r3_rem;
    logic [TIME_W-1:0]      r3_time;
    logic [DIST_W-1:0]      r4_base;
    logic [DIST_W-1:0]      r4_diff;
    logic                   r4_up;
    logic [REM_W-1:0]       r4_rem;
    logic [TIME_W-1:0]      r4_time;
    logic [B_W-1:0]         r5_b;
    logic [DIST_W-1:0]      r5_base;
    logic                   r5_up;
    logic [TIME_W-1:0]      r5_time;
    logic [B_W-1:0]         r6_q0;
    logic [B_W-1:0]         r6_b;
    logic [DIST_W-1:0]      r6_base;
    logic                   r6_up;
    logic [TIME_W-1:0]      r6_time;
    logic [DIST_W-1:0]      r7_dist;
    logic [TIME_W-1:0]      r7_time;
    logic                   r_phase;
    logic [TIME_W-1:0]      r_last_toggle;
    logic                   n_phase;
    logic [TIME_W-1:0]      n_last_toggle;

    logic [NUM_W-1:0]   w_num;
    logic [2*A_W-1:0]   w_prod1;
    logic [A_W-1:0]     w_r0;
    logic               w_wrap;
    logic [DIST_W-1:0]  w_cur0;
    logic [DIST_W-1:0]  w_cur1;
    logic               w_up;
    logic [P2_W-1:0]    w_prod2;
    logic [2*B_W-1:0]   w_prod3;
    logic [B_W-1:0]     w_rb;
    logic               w_fix;
    logic [DIST_W-1:0]  w_q;
    logic [DIST_W-1:0]  w_dist;
    logic [DIST_W-1:0]  w_range;
    logic [DIST_W-1:0]  w_near;
    logic [DIST_W-1:0]  w_middle;
    logic [DIST_W-1:0]  w_far;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_alarm;

    assign w_en     = !r_v7 || !i_res_full;
    assign o_pop    = w_en && i_item_avail;
    assign o_res_wr = r_v7 && !i_res_full;

    // position on the curve: sum * segments / (window * 2^sample_bits)
    assign w_num   = NUM_W'(i_sum) * NUM_W'(CURVE_SEGMENTS);
    assign w_prod1 = (2*A_W)'(r1_a) * (2*A_W)'(M1);
    assign w_r0    = r2_a - r2_q0 * A_W'(WINDOW);
    assign w_wrap  = (w_r0 >= A_W'(WINDOW));

    assign w_cur0  = w_curve[SEG_W'(r3_k)];
    assign w_cur1  = w_curve[SEG_W'(r3_k) + SEG_W'(1)];
    assign w_up    = (w_cur1 > w_cur0);

    // interpolation step: diff * rem / (window * 2^sample_bits)
    assign w_prod2 = P2_W'(r4_diff) * P2_W'(r4_rem);
    assign w_prod3 = (2*B_W)'(r5_b) * (2*B_W)'(M2);
    assign w_rb    = r6_b - r6_q0 * B_W'(WINDOW);
    assign w_fix   = (w_rb >= B_W'(WINDOW));
    assign w_q     = DIST_W'(r6_q0 + B_W'(w_fix));
    assign w_dist  = r6_up ? r6_base + w_q : r6_base - w_q;
    assign w_range = {i_cfg.range_limit_cm, {idaz_pkg::FRAC_W{1'b0}}};

    assign w_near    = {i_cfg.near_limit_cm, {idaz_pkg::FRAC_W{1'b0}}};
    assign w_middle  = {i_cfg.middle_limit_cm, {idaz_pkg::FRAC_W{1'b0}}};
    assign w_far     = {i_cfg.far_limit_cm, {idaz_pkg::FRAC_W{1'b0}}};
    assign w_alarm   = (r7_dist < w_near);
    assign w_elapsed = r7_time - r_last_toggle;

    always_comb begin
        n_phase       = r_phase;
        n_last_toggle = r_last_toggle;
        if (w_alarm) begin
            if (w_elapsed >= TIME_W'(i_cfg.blink_interval_ms)) begin
                n_phase       = !r_phase;
                n_last_toggle = r7_time;
            end
        end else begin
            n_phase       = 1'b0;
            n_last_toggle = r7_time;
        end
    end

    always_comb begin
        o_result.distance_q8  = r7_dist;
        o_result.far_on       = !w_alarm && (r7_dist > w_far);
        o_result.middle_on    = !w_alarm && (r7_dist > w_middle);
        o_result.near_on      = !w_alarm && (r7_dist > w_near);
        o_result.alarm_active = w_alarm;
        o_result.alarm_red    = n_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_v3          <= 1'b0;
            r_v4          <= 1'b0;
            r_v5          <= 1'b0;
            r_v6          <= 1'b0;
            r_v7          <= 1'b0;
            r_phase       <= 1'b0;
            r_last_toggle <= '0;
        end else begin
            if (w_en) begin
                r_v1 <= o_pop;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
                r_v4 <= r_v3;
                r_v5 <= r_v4;
                r_v6 <= r_v5;
                r_v7 <= r_v6;
            end
            if (o_res_wr) begin
                r_phase       <= n_phase;
                r_last_toggle <= n_last_toggle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a    <= w_num[NUM_W-1:SAMPLE_BITS];
            r1_lo   <= w_num[SAMPLE_BITS-1:0];
            r1_time <= i_time_ms;

            r2_q0   <= w_prod1[2*A_W-1:A_W];
            r2_a    <= r1_a;
            r2_lo   <= r1_lo;
            r2_time <= r1_time;

            r3_k    <= K_W'(r2_q0 + A_W'(w_wrap));
            r3_rem  <= {RW_W'(w_wrap ? w_r0 - A_W'(WINDOW) : w_r0), r2_lo};
            r3_time <= r2_time;

            r4_base <= w_cur0;
            r4_diff <= w_up ? w_cur1 - w_cur0 : w_cur0 - w_cur1;
            r4_up   <= w_up;
            r4_rem  <= r3_rem;
            r4_time <= r3_time;

            r5_b    <= w_prod2[P2_W-1:SAMPLE_BITS];
            r5_base <= r4_base;
            r5_up   <= r4_up;
            r5_time <= r4_time;

            r6_q0   <= w_prod3[2*B_W-1:B_W];
            r6_b    <= r5_b;
            r6_base <= r5_base;
            r6_up   <= r5_up;
            r6_time <= r5_time;

            r7_dist <= (w_dist > w_range) ? w_range : w_dist;
            r7_time <= r6_time;
        end
    end

endmodule

// File: sv/ir_distance_average_zone.sv
// Moving-average infrared range converter. Each request carries an ADC sample and a
// millisecond timestamp; the block averages the last WINDOW samples, maps the mean onto
// the distance curve by table interpolation and returns one result per request: the
// distance in unsigned Q7.8 cm clamped to the range limit, the far, middle and near
// zone flags and the alarm and blink phase. One request is taken every clock cycle while
// the request queue is not full; a request passes through a four-entry request queue and
// the seven-stage divide and interpolation pipeline on its way to the result queue.
// The sample ring needs no clearing pass after reset, and the configuration port is
// always ready; the user must write limits while no request is in flight (unenforced).
module ir_distance_average_zone #(
    parameter int WINDOW         = 10,
    parameter int SAMPLE_BITS    = 10,
    parameter int CURVE_SEGMENTS = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [SAMPLE_BITS-1:0]             i_sample,
    input  logic [idaz_pkg::TIME_W-1:0]        i_time_ms,
    output logic                               empty,
    input  logic                               pop,
    output logic [idaz_pkg::DIST_W-1:0]        o_distance_q8,
    output logic                               o_far_on,
    output logic                               o_middle_on,
    output logic                               o_near_on,
    output logic                               o_alarm_active,
    output logic                               o_alarm_red,
    input  logic                               valid,
    output logic                               ready,
    input  logic [idaz_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [idaz_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int SUM_W   = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int TIME_W  = idaz_pkg::TIME_W;
    localparam int MID_W   = SUM_W + TIME_W;
    localparam int MID_D   = 4;
    localparam int RES_W   = $bits(idaz_pkg::t_result);
    localparam int RES_D   = 2;
    localparam int LIMIT_W = idaz_pkg::LIMIT_W;

    idaz_pkg::t_cfg    r_cfg;
    idaz_pkg::t_result w_result;
    idaz_pkg::t_result w_out;

    logic              w_front_wr;
    logic [SUM_W-1:0]  w_front_sum;
    logic              w_mid_empty;
    logic [MID_W-1:0]  w_mid_data;
    logic              w_pop_mid;
    logic              w_res_full;
    logic              w_res_wr;
    logic [RES_W-1:0]  w_out_bits;

    assign ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.near_limit_cm     <= idaz_pkg::NEAR_LIMIT_RST;
            r_cfg.middle_limit_cm   <= idaz_pkg::MIDDLE_LIMIT_RST;
            r_cfg.far_limit_cm      <= idaz_pkg::FAR_LIMIT_RST;
            r_cfg.range_limit_cm    <= idaz_pkg::RANGE_LIMIT_RST;
            r_cfg.blink_interval_ms <= idaz_pkg::BLINK_INTERVAL_RST;
        end else if (valid && ready) begin
            case (i_cfg_index)
                idaz_pkg::CFG_NEAR_LIMIT: begin
                    r_cfg.near_limit_cm <= i_cfg_data[LIMIT_W-1:0];
                end
                idaz_pkg::CFG_MIDDLE_LIMIT: begin
                    r_cfg.middle_limit_cm <= i_cfg_data[LIMIT_W-1:0];
                end
                idaz_pkg::CFG_FAR_LIMIT: begin
                    r_cfg.far_limit_cm <= i_cfg_data[LIMIT_W-1:0];
                end
                idaz_pkg::CFG_RANGE_LIMIT: begin
                    r_cfg.range_limit_cm <= i_cfg_data[LIMIT_W-1:0];
                end
                idaz_pkg::CFG_BLINK_INTERVAL: begin
                    r_cfg.blink_interval_ms <= i_cfg_data;
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    idaz_front #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_W       (SUM_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_full   (full),
        .i_sample (i_sample),
        .o_wr     (w_front_wr),
        .o_sum    (w_front_sum)
    );

    idaz_queue #(
        .WIDTH (MID_W),
        .DEPTH (MID_D)
    ) u_mid_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_front_wr),
        .i_wr_data ({w_front_sum, i_time_ms}),
        .o_full    (full),
        .i_rd      (w_pop_mid),
        .o_empty   (w_mid_empty),
        .o_rd_data (w_mid_data)
    );

    idaz_back #(
        .WINDOW         (WINDOW),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .CURVE_SEGMENTS (CURVE_SEGMENTS),
        .SUM_W          (SUM_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_avail (!w_mid_empty),
        .i_sum        (w_mid_data[MID_W-1:TIME_W]),
        .i_time_ms    (w_mid_data[TIME_W-1:0]),
        .o_pop        (w_pop_mid),
        .i_res_full   (w_res_full),
        .o_res_wr     (w_res_wr),
        .o_result     (w_result)
    );

    idaz_queue #(
        .WIDTH (RES_W),
        .DEPTH (RES_D)
    ) u_res_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_res_wr),
        .i_wr_data (w_result),
        .o_full    (w_res_full),
        .i_rd      (pop),
        .o_empty   (empty),
        .o_rd_data (w_out_bits)
    );

    assign w_out          = idaz_pkg::t_result'(w_out_bits);
    assign o_distance_q8  = w_out.distance_q8;
    assign o_far_on       = w_out.far_on;
    assign o_middle_on    = w_out.middle_on;
    assign o_near_on      = w_out.near_on;
    assign o_alarm_active = w_out.alarm_active;
    assign o_alarm_red    = w_out.alarm_red;

endmodule

// File: sv/idaz_checker.sv
module idaz_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [14:0] o_distance_q8,
    input logic        o_far_on,
    input logic        o_middle_on,
    input logic        o_near_on,
    input logic        o_alarm_active,
    input logic        o_alarm_red
);

    // no result straight out of reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> empty)
        else $error("result present right after reset");

    // zone flags are masked while the alarm holds
    a_zones_off_in_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_alarm_active) |-> (!o_near_on && !o_middle_on && !o_far_on))
        else $error("zone flag set during alarm");

    // blink phase only shown during alarm
    a_red_needs_alarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_alarm_red) |-> o_alarm_active)
        else $error("blink phase set without alarm");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_distance_q8) && $stable(o_alarm_red)))
        else $error("waiting result changed");

endmodule

bind ir_distance_average_zone idaz_checker u_idaz_checker (.*);
